// File: design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the radial spotlight dimmer pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

	localparam int MAX_DIM  = 1024;
	localparam int LUM_BITS = 16;

	localparam int COORD_W = 10;
	localparam int LUM_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [COORD_W-1:0] COORD_MAX =
		(MAX_DIM - 1 > 1023) ? COORD_W'(1023) : COORD_W'(MAX_DIM - 1);

	localparam logic [LUM_W-1:0] LUM_MASK =
		(LUM_BITS >= LUM_W) ? {LUM_W{1'b1}} : LUM_W'((1 << LUM_BITS) - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);

	localparam int D2_W   = 2 * COORD_W + 1;
	localparam int RAD_W  = 32;
	localparam int REM_W  = 20;
	localparam int ROOT_W = 16;

	localparam int SQRT_ITERS      = ROOT_W;
	localparam int ITERS_PER_STAGE = 2;
	localparam int SQRT_STAGES     = SQRT_ITERS / ITERS_PER_STAGE;

	// Distances of 160 pixels and beyond hit the dimming cap.
	localparam logic [D2_W-1:0] D2_CAP = D2_W'(25600);

	localparam int RECIP_W     = 22;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(2684355);
	localparam int PROD_W = ROOT_W + RECIP_W;

	localparam int KEEP_W = 17;
	localparam logic [KEEP_W-1:0] ONE_Q16  = KEEP_W'(65536);
	localparam logic [KEEP_W-1:0] KEEP_CAP = KEEP_W'(65536 - 52428);

	localparam int LATENCY = 2 + SQRT_STAGES + 3;

	typedef struct packed {
		logic                  cap;
		logic [RAD_W-1:0]      rad;
		logic [REM_W-1:0]      rem;
		logic [ROOT_W-1:0]     root;
		logic [LUM_W-1:0]      lum;
	} rsd_sq_t;

endpackage

`default_nettype wire

// File: design/rsd_dist.sv
// ----------------------------------------------------------------------------
// rsd_dist
// Clamps the coordinates, forms the offsets to the center and the squared
// distance, and seeds the square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_dist (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_vld,
	input  wire logic [rsd_pkg::COORD_W-1:0] pix_x,
	input  wire logic [rsd_pkg::COORD_W-1:0] pix_y,
	input  wire logic [rsd_pkg::LUM_W-1:0]   lum_in,
	input  wire logic [rsd_pkg::COORD_W-1:0] center_x,
	input  wire logic [rsd_pkg::COORD_W-1:0] center_y,
	output logic                             vld_out,
	output rsd_pkg::rsd_sq_t                 sq_out
);
	import rsd_pkg::*;

	logic [COORD_W-1:0] px, py, cx, cy;
	logic [COORD_W-1:0] dx_d, dy_d;
	logic               vld_s1, vld_s2;
	logic [COORD_W-1:0] dx_s1, dy_s1;
	logic [LUM_W-1:0]   lum_s1;
	logic [D2_W-1:0]    d2;
	rsd_sq_t            sq_s2;

	always_comb begin
		px = (pix_x > COORD_MAX) ? COORD_MAX : pix_x;
		py = (pix_y > COORD_MAX) ? COORD_MAX : pix_y;
		cx = (center_x > COORD_MAX) ? COORD_MAX : center_x;
		cy = (center_y > COORD_MAX) ? COORD_MAX : center_y;
		dx_d = (px >= cx) ? px - cx : cx - px;
		dy_d = (py >= cy) ? py - cy : cy - py;
	end

	always_comb begin
		d2 = D2_W'(dx_s1 * dx_s1) + D2_W'(dy_s1 * dy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx_d;
		dy_s1  <= dy_d;
		lum_s1 <= lum_in & LUM_MASK;
		sq_s2.cap  <= (d2 >= D2_CAP);
		sq_s2.rad  <= {1'b0, d2[14:0], 16'b0};
		sq_s2.rem  <= '0;
		sq_s2.root <= '0;
		sq_s2.lum  <= lum_s1;
	end

	assign vld_out = vld_s2;
	assign sq_out  = sq_s2;

endmodule

`default_nettype wire

// File: design/rsd_sqrt_stage.sv
// ----------------------------------------------------------------------------
// rsd_sqrt_stage
// One register stage of the restoring square root: two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_sqrt_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_in,
	input  wire rsd_pkg::rsd_sq_t sq_in,
	output logic                  vld_out,
	output rsd_pkg::rsd_sq_t      sq_out
);
	import rsd_pkg::*;

	logic    vld_sn;
	rsd_sq_t sq_sn;
	rsd_sq_t nxt;

	always_comb begin
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		nxt = sq_in;
		for (int i = 0; i < ITERS_PER_STAGE; i++) begin
			rem_sh  = {nxt.rem[REM_W-3:0], nxt.rad[RAD_W-1 -: 2]};
			nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
			trial   = REM_W'({nxt.root, 2'b01});
			if (rem_sh >= trial) begin
				nxt.rem  = rem_sh - trial;
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem_sh;
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		sq_sn <= nxt;
	end

	assign vld_out = vld_sn;
	assign sq_out  = sq_sn;

endmodule

`default_nettype wire

// File: design/rsd_scale.sv
// ----------------------------------------------------------------------------
// rsd_scale
// Turns the distance into a dimming factor, caps it, and scales the luminance.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_scale (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      vld_in,
	input  wire rsd_pkg::rsd_sq_t          sq_in,
	output logic                           done,
	output logic [rsd_pkg::LUM_W-1:0]      lum_out
);
	import rsd_pkg::*;

	logic                vld_s11, vld_s12, vld_s13;
	logic [PROD_W-1:0]   prod_s11;
	logic                cap_s11;
	logic [LUM_W-1:0]    lum_s11, lum_s12;
	logic [KEEP_W-1:0]   keep_s12;
	logic [LUM_W-1:0]    lum_s13;
	logic [ROOT_W-1:0]   dim;
	logic [LUM_W+KEEP_W-1:0] scaled;

	always_comb begin
		dim    = prod_s11[RECIP_SHIFT +: ROOT_W];
		scaled = (LUM_W + KEEP_W)'(lum_s12) * (LUM_W + KEEP_W)'(keep_s12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s11 <= vld_in;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		prod_s11 <= PROD_W'(sq_in.root) * PROD_W'(RECIP_25);
		cap_s11  <= sq_in.cap;
		lum_s11  <= sq_in.lum;
		keep_s12 <= cap_s11 ? KEEP_CAP : ONE_Q16 - KEEP_W'(dim);
		lum_s12  <= lum_s11;
		lum_s13  <= scaled[16 +: LUM_W];
	end

	assign done    = vld_s13;
	assign lum_out = lum_s13;

endmodule

`default_nettype wire

// File: design/radial_spotlight_dimmer.sv
// ----------------------------------------------------------------------------
// radial_spotlight_dimmer
// Radial vignette with linear falloff around a configurable center.
// ----------------------------------------------------------------------------
// An accepted pixel runs through rsd_dist, the sqrt stages and rsd_scale.
// Throughput: one pixel per cycle; busy is never raised.
// Eight of the stages are the square root, two result bits per stage.
// Reset clears the valid bits and sets both center registers to zero.
// The receiver cannot stall; every result is shown for one cycle.
`default_nettype none

module radial_spotlight_dimmer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rsd_pkg::COORD_W-1:0]   pix_x,
	input  wire logic [rsd_pkg::COORD_W-1:0]   pix_y,
	input  wire logic [rsd_pkg::LUM_W-1:0]     lum_in,
	output logic                               done,
	output logic [rsd_pkg::LUM_W-1:0]          lum_out,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rsd_pkg::*;

	logic [COORD_W-1:0] center_x_q, center_y_q;
	logic               vld_c [SQRT_STAGES+1];
	rsd_sq_t            sq_c  [SQRT_STAGES+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_data[COORD_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	rsd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.pix_x    (pix_x),
		.pix_y    (pix_y),
		.lum_in   (lum_in),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.vld_out  (vld_c[0]),
		.sq_out   (sq_c[0])
	);

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		rsd_sqrt_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[g]),
			.sq_in   (sq_c[g]),
			.vld_out (vld_c[g+1]),
			.sq_out  (sq_c[g+1])
		);
	end

	rsd_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_c[SQRT_STAGES]),
		.sq_in   (sq_c[SQRT_STAGES]),
		.done    (done),
		.lum_out (lum_out)
	);

endmodule

`default_nettype wire

// File: design/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks of the radial spotlight dimmer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic [rsd_pkg::LUM_W-1:0]     lum_in,
	input  wire logic                          done,
	input  wire logic [rsd_pkg::LUM_W-1:0]     lum_out,
	input  wire logic                          cfg_ready
);
	import rsd_pkg::*;

	// A result only follows a matching input transfer.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without a matching input transfer");

	// Dimming never brightens a pixel.
	a_no_brighten: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> lum_out <= $past(lum_in, LATENCY))
		else $error("output luminance above input luminance");

	// A black pixel stays black.
	a_black_stays: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(lum_in == '0, LATENCY) |-> lum_out == '0)
		else $error("black pixel came out nonzero");

	// The pipeline never pushes back.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block refused a transfer");

endmodule

bind radial_spotlight_dimmer rsd_checker u_rsd_checker (.*);

`default_nettype wire
